[hw/rtl/lpfp_pkg.sv]
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types and constants of the length-prefixed frame parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

    localparam int unsigned HdrBytes = 12;
    localparam int unsigned CfgDataW = 32;
    localparam int unsigned CfgIdxW  = 2;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BAD_MAGIC   = 2'd1,
        ST_BAD_VERSION = 2'd2,
        ST_TOO_LARGE   = 2'd3
    } t_status;

    typedef enum logic [CfgIdxW-1:0] {
        REG_MAGIC      = 2'd0,
        REG_VERSION    = 2'd1,
        REG_MAX_LENGTH = 2'd2,
        REG_BIG_ENDIAN = 2'd3
    } t_reg_idx;

    // byte k is the k-th byte received of the header
    typedef logic [HdrBytes-1:0][7:0] t_hdr;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [31:0] max_length;
        logic        big_endian;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [15:0] frame_type;
        logic [31:0] length;
    } t_hdr_chk;

endpackage

[hw/rtl/lpfp_hdr_check.sv]
// ----------------------------------------------------------------------------
// lpfp_hdr_check
// Assembles the header fields in the configured byte order and checks
// magic, version and payload length.
// ----------------------------------------------------------------------------
module lpfp_hdr_check (
    input  lpfp_pkg::t_hdr     i_hdr,
    input  lpfp_pkg::t_cfg     i_cfg,
    output lpfp_pkg::t_hdr_chk o_chk
);

    logic [31:0] w_magic;
    logic [15:0] w_version;
    logic [15:0] w_type;
    logic [31:0] w_length;

    always_comb begin
        if (i_cfg.big_endian) begin
            w_magic   = {i_hdr[0], i_hdr[1], i_hdr[2], i_hdr[3]};
            w_version = {i_hdr[4], i_hdr[5]};
            w_type    = {i_hdr[6], i_hdr[7]};
            w_length  = {i_hdr[8], i_hdr[9], i_hdr[10], i_hdr[11]};
        end else begin
            w_magic   = {i_hdr[3], i_hdr[2], i_hdr[1], i_hdr[0]};
            w_version = {i_hdr[5], i_hdr[4]};
            w_type    = {i_hdr[7], i_hdr[6]};
            w_length  = {i_hdr[11], i_hdr[10], i_hdr[9], i_hdr[8]};
        end
    end

    always_comb begin
        o_chk.frame_type = w_type;
        o_chk.length     = w_length;
        if (w_magic != i_cfg.magic) begin
            o_chk.status = lpfp_pkg::ST_BAD_MAGIC;
        end else if (w_version != i_cfg.version) begin
            o_chk.status = lpfp_pkg::ST_BAD_VERSION;
        end else if (w_length > i_cfg.max_length) begin
            o_chk.status = lpfp_pkg::ST_TOO_LARGE;
        end else begin
            o_chk.status = lpfp_pkg::ST_OK;
        end
    end

endmodule

[hw/rtl/length_prefixed_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_unit
// Deframes a byte stream of 12-byte headers and payloads, streaming payload
// bytes out tagged with the frame type.
// ----------------------------------------------------------------------------
// One byte is taken per clock and its result, if any, appears in the output
// register on the next cycle; a new byte is taken even while that result is
// still waiting, so the block sustains one byte per cycle and stalls its
// input only while the output register is full and stalled. Header bytes
// give no result until the twelfth, where the header is checked as that
// byte is taken: a bad header gives one error result and the block drops
// every byte until reset; a zero-length frame gives one empty-frame result.
module length_prefixed_frame_parser_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [lpfp_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [lpfp_pkg::CfgDataW-1:0]      i_cfg_data,
    // byte input
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [7:0]                         i_in_byte,
    // result output
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [1:0]                         o_kind,
    output logic [15:0]                        o_frame_type,
    output logic [7:0]                         o_data_byte,
    output logic                               o_last_of_frame,
    output logic [1:0]                         o_status
);

    lpfp_pkg::t_cfg r_cfg;

    lpfp_pkg::t_phase r_phase, n_phase;
    logic [3:0]       r_hdr_cnt, n_hdr_cnt;
    logic [10:0][7:0] r_hdr_sh;
    logic [15:0]      r_cur_type, n_cur_type;
    logic [31:0]      r_bytes_left, n_bytes_left;

    logic             r_out_valid;
    lpfp_pkg::t_kind  r_out_kind;
    logic [15:0]      r_out_type;
    logic [7:0]       r_out_data;
    logic             r_out_last;
    lpfp_pkg::t_status r_out_status;

    logic              w_in_acc;
    logic              w_out_free;
    logic              w_res_valid;
    lpfp_pkg::t_kind   w_res_kind;
    logic [15:0]       w_res_type;
    logic [7:0]        w_res_data;
    logic              w_res_last;
    lpfp_pkg::t_status w_res_status;

    lpfp_pkg::t_hdr     w_hdr;
    lpfp_pkg::t_hdr_chk w_chk;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic      <= '0;
            r_cfg.version    <= 16'd1;
            r_cfg.max_length <= 32'd65536;
            r_cfg.big_endian <= 1'b1;
        end else if (i_cfg_we) begin
            case (lpfp_pkg::t_reg_idx'(i_cfg_index))
                lpfp_pkg::REG_MAGIC:      r_cfg.magic      <= i_cfg_data;
                lpfp_pkg::REG_VERSION:    r_cfg.version    <= i_cfg_data[15:0];
                lpfp_pkg::REG_MAX_LENGTH: r_cfg.max_length <= i_cfg_data;
                lpfp_pkg::REG_BIG_ENDIAN: r_cfg.big_endian <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = !w_out_free;
    assign w_in_acc   = i_valid && w_out_free;

    // header as seen when the current byte is the last one
    always_comb begin
        for (int k = 0; k < lpfp_pkg::HdrBytes - 1; k++) begin
            w_hdr[k] = r_hdr_sh[k];
        end
        w_hdr[lpfp_pkg::HdrBytes-1] = i_in_byte;
    end

    lpfp_hdr_check u_hdr_check (
        .i_hdr (w_hdr),
        .i_cfg (r_cfg),
        .o_chk (w_chk)
    );

    always_comb begin
        n_phase      = r_phase;
        n_hdr_cnt    = r_hdr_cnt;
        n_cur_type   = r_cur_type;
        n_bytes_left = r_bytes_left;
        w_res_valid  = 1'b0;
        w_res_kind   = lpfp_pkg::KIND_PAYLOAD;
        w_res_type   = r_cur_type;
        w_res_data   = 8'd0;
        w_res_last   = 1'b0;
        w_res_status = lpfp_pkg::ST_OK;
        case (r_phase)
            lpfp_pkg::PH_PAYLOAD: begin
                // bytes_left is at least one in this phase
                w_res_valid  = 1'b1;
                w_res_data   = i_in_byte;
                w_res_last   = (r_bytes_left == 32'd1);
                n_bytes_left = r_bytes_left - 32'd1;
                if (r_bytes_left == 32'd1) begin
                    n_phase   = lpfp_pkg::PH_HEADER;
                    n_hdr_cnt = '0;
                end
            end
            lpfp_pkg::PH_HEADER: begin
                if (r_hdr_cnt == 4'(lpfp_pkg::HdrBytes - 1)) begin
                    n_hdr_cnt  = '0;
                    w_res_type = w_chk.frame_type;
                    if (w_chk.status != lpfp_pkg::ST_OK) begin
                        w_res_valid  = 1'b1;
                        w_res_kind   = lpfp_pkg::KIND_ERROR;
                        w_res_status = w_chk.status;
                        n_phase      = lpfp_pkg::PH_ERROR;
                    end else begin
                        n_cur_type = w_chk.frame_type;
                        if (w_chk.length == 32'd0) begin
                            w_res_valid  = 1'b1;
                            w_res_kind   = lpfp_pkg::KIND_EMPTY;
                            w_res_last   = 1'b1;
                            n_bytes_left = '0;
                        end else begin
                            n_bytes_left = w_chk.length;
                            n_phase      = lpfp_pkg::PH_PAYLOAD;
                        end
                    end
                end else begin
                    n_hdr_cnt = r_hdr_cnt + 4'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= lpfp_pkg::PH_HEADER;
            r_hdr_cnt    <= '0;
            r_cur_type   <= '0;
            r_bytes_left <= '0;
        end else if (w_in_acc) begin
            r_phase      <= n_phase;
            r_hdr_cnt    <= n_hdr_cnt;
            r_cur_type   <= n_cur_type;
            r_bytes_left <= n_bytes_left;
        end
    end

    // header byte shift line, oldest byte at index 0
    always_ff @(posedge i_clk) begin
        if (w_in_acc && r_phase == lpfp_pkg::PH_HEADER) begin
            r_hdr_sh <= {i_in_byte, r_hdr_sh[10:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_in_acc && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_res_valid) begin
            r_out_kind   <= w_res_kind;
            r_out_type   <= w_res_type;
            r_out_data   <= w_res_data;
            r_out_last   <= w_res_last;
            r_out_status <= w_res_status;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_kind          = r_out_kind;
    assign o_frame_type    = r_out_type;
    assign o_data_byte     = r_out_data;
    assign o_last_of_frame = r_out_last;
    assign o_status        = r_out_status;

endmodule
